@@ src/kmt_pkg.sv @@
// shared types and constants for the keyed message table
// no dependencies
`timescale 1ns / 1ps

package kmt_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] OP_UPSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [31:0] magic;
		logic [7:0]  code;
		logic [31:0] block;
	} msg_t;

	typedef struct packed {
		logic [15:0] key;
		msg_t        msg;
	} entry_t;

	typedef struct packed {
		logic        en;
		logic [1:0]  op;
		logic [15:0] key;
		msg_t        msg;
		logic        any_hit;
	} cmd_t;

endpackage

@@ src/kmt_cell.sv @@
// one table entry: key compare, in-place update, append and shift-down
// depends on kmt_pkg
`timescale 1ns / 1ps

module kmt_cell import kmt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  logic   prev_valid,
	input  logic   hit_in,
	input  msg_t   rd_in,
	input  logic   nxt_valid,
	input  entry_t nxt_entry,
	output logic   valid,
	output entry_t entry,
	output logic   hit_out,
	output msg_t   rd_out
);

	logic   valid_q;
	entry_t entry_q;
	logic   match;
	logic   do_upd;
	logic   do_app;
	logic   do_shift;

	assign match    = valid_q && (entry_q.key == cmd.key);
	assign hit_out  = hit_in | match;
	assign rd_out   = match ? (rd_in | entry_q.msg) : rd_in;
	assign valid    = valid_q;
	assign entry    = entry_q;

	assign do_upd   = cmd.en && (cmd.op == OP_UPSERT) && match;
	assign do_app   = cmd.en && (cmd.op == OP_UPSERT) && !cmd.any_hit && !valid_q && prev_valid;
	assign do_shift = cmd.en && (cmd.op == OP_REMOVE) && hit_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (do_app) begin
			valid_q <= 1'b1;
		end else if (do_shift) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (do_app) begin
			entry_q <= '{key: cmd.key, msg: cmd.msg};
		end else if (do_upd) begin
			entry_q.msg <= cmd.msg;
		end else if (do_shift) begin
			entry_q <= nxt_entry;
		end
	end

endmodule

@@ src/keyed_message_table_core.sv @@
// keyed message table top level: row of kmt_cell entries and result register
// depends on kmt_pkg and kmt_cell
//
// channel  dir  tdata (low bit up)                     tuser (low bit up)
// s_*      in   conn_key, magic_in, code_in, block_in  op
// m_*      out  magic_out, code_out, block_out,        status, hit
//               entry_count, zero pad
//
// one word per cycle while s_tready is high: a command is applied to all cells at the edge it is accepted
// the result is captured in the output register at that same edge
// s_tready is low only while a result waits and m_tready is low
// reset empties the table at once (cell valid bits and entry count)
`timescale 1ns / 1ps

module keyed_message_table_core import kmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // conn_key, magic_in, code_in, block_in
	input  logic [1:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // magic_out, code_out, block_out, entry_count, pad
	output logic [2:0]  m_tuser    // status, hit
);

	cmd_t             cmd;
	logic             accept;
	logic [DEPTH-1:0] valid_w;
	entry_t           entry_w [DEPTH];
	logic             hit_chain [DEPTH+1];
	msg_t             rd_chain [DEPTH+1];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             full;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic             hit_q;
	msg_t             rd_q;
	logic [CNT_W-1:0] ocount_q;
	logic [1:0]       status_nxt;
	logic             hit_nxt;
	msg_t             rd_nxt;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(DEPTH));

	assign cmd.en        = accept;
	assign cmd.op        = s_tuser;
	assign cmd.key       = s_tdata[15:0];
	assign cmd.msg.magic = s_tdata[47:16];
	assign cmd.msg.code  = s_tdata[55:48];
	assign cmd.msg.block = s_tdata[87:56];
	assign cmd.any_hit   = hit_chain[DEPTH];

	assign hit_chain[0] = 1'b0;
	assign rd_chain[0]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   pv;
		logic   nv;
		entry_t ne;
		if (i == 0) begin : g_first
			assign pv = 1'b1;
		end else begin : g_mid
			assign pv = valid_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign nv = 1'b0;
			assign ne = '0;
		end else begin : g_inner
			assign nv = valid_w[i+1];
			assign ne = entry_w[i+1];
		end
		kmt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_valid (pv),
			.hit_in     (hit_chain[i]),
			.rd_in      (rd_chain[i]),
			.nxt_valid  (nv),
			.nxt_entry  (ne),
			.valid      (valid_w[i]),
			.entry      (entry_w[i]),
			.hit_out    (hit_chain[i+1]),
			.rd_out     (rd_chain[i+1])
		);
	end

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_OK;
		hit_nxt    = 1'b0;
		rd_nxt     = '0;
		unique case (cmd.op)
			OP_UPSERT: begin
				hit_nxt = cmd.any_hit;
				if (!cmd.any_hit) begin
					if (full) begin
						status_nxt = ST_FULL;
					end else begin
						count_nxt = count_q + CNT_W'(1);
					end
				end
			end
			OP_REMOVE: begin
				hit_nxt = cmd.any_hit;
				if (cmd.any_hit) begin
					count_nxt = count_q - CNT_W'(1);
				end else begin
					status_nxt = ST_NOT_FOUND;
				end
			end
			OP_LOOKUP: begin
				hit_nxt = cmd.any_hit;
				if (cmd.any_hit) begin
					rd_nxt = rd_chain[DEPTH];
				end else begin
					status_nxt = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			hit_q    <= hit_nxt;
			rd_q     <= rd_nxt;
			ocount_q <= count_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {hit_q, status_q};
	assign m_tdata  = {(80 - 72 - CNT_W)'(0), ocount_q, rd_q.block, rd_q.code, rd_q.magic};

	// occupied cells always form a contiguous run that the counter tracks
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == int'(count_q))
		else $error("entry count differs from occupied cells");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above table depth");

	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd.op == OP_REMOVE) && cmd.any_hit |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("remove hit did not shrink the table");

	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == ST_FULL) |-> !m_tuser[2] && (ocount_q == CNT_W'(DEPTH)))
		else $error("full status with hit or short table");

endmodule
